>>> sv/bra_pkg.sv
`timescale 1ns / 1ps

package bra_pkg;

	// Field widths of the request and response words.
	localparam int MODE_W   = 3;
	localparam int BIT_W    = 10;
	localparam int LEN_W    = 11;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 6;

	// Map geometry: 32-bit words, enough of them to cover every bit index.
	localparam int WORD_BITS = 32;
	localparam int WORD_SH   = $clog2(WORD_BITS);
	localparam int ADDR_W    = BIT_W - WORD_SH;
	localparam int MAP_WORDS = 2 ** ADDR_W;

	localparam logic [CFG_W-1:0] WIU_RESET = CFG_W'(MAP_WORDS);

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_SEARCH      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SET_BIT     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR_BIT   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SET_RANGE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR_RANGE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR_ALL   = 3'd5;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd2;

	// How a request is carried out, as seen after decode.
	localparam logic [1:0] KIND_EARLY  = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_RMW    = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	// Which result the datapath captures.
	localparam logic [1:0] CAP_EARLY = 2'd0;
	localparam logic [1:0] CAP_HIT   = 2'd1;
	localparam logic [1:0] CAP_MISS  = 2'd2;
	localparam logic [1:0] CAP_DONE  = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BIT_W-1:0]  start_bit;
		logic [LEN_W-1:0]  run_length;
	} bra_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BIT_W-1:0]    found_bit;
	} bra_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_req;
		logic       load_ptr;
		logic       clear_map;
		logic       rd_en;
		logic       wr_en;
		logic       capture;
		logic [1:0] cap_sel;
		logic       rsp_load;
	} bra_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] kind;
		logic       is_search;
		logic       rd_at_last;
		logic       hit;
	} bra_sts_t;

endpackage

>>> sv/bra_ram.sv
`timescale 1ns / 1ps

module bra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/bra_datapath.sv
`timescale 1ns / 1ps

module bra_datapath import bra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bra_req_t         req,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  bra_cmd_t         cmd,
	output bra_sts_t         sts,
	output bra_rsp_t         rsp
);

	logic [CFG_W-1:0]     wiu_q;
	logic [MODE_W-1:0]    mode_q;
	logic [BIT_W-1:0]     start_q;
	logic [LEN_W-1:0]     len_q;
	logic [CFG_W-1:0]     words_used;
	logic [LEN_W-1:0]     total;
	logic [LEN_W:0]       end_bit;
	logic [BIT_W-1:0]     last_bit;
	logic [1:0]           kind;
	logic                 is_search;
	logic                 is_set;
	logic [STATUS_W-1:0]  early_st;
	logic [ADDR_W-1:0]    rd_ptr_q;
	logic [ADDR_W-1:0]    last_q;
	logic                 rd_valid_s1;
	logic [ADDR_W-1:0]    word_idx_s1;
	logic                 vld_s1;
	logic [MAP_WORDS-1:0] valid_q;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] word_cur;
	logic [WORD_BITS-1:0] new_word;
	logic                 wr_fire;
	logic [LEN_W-1:0]     carry_q;
	logic [LEN_W-1:0]     carry_nxt;
	logic [WORD_BITS-1:0] hit_vec;
	logic                 hit_any;
	logic [WORD_SH-1:0]   hit_pos;
	logic [LEN_W-1:0]     found_calc;
	bra_rsp_t             res_q;
	bra_rsp_t             rsp_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q <= WIU_RESET;
		end else if (cfg_we) begin
			wiu_q <= cfg_wdata;
		end
	end

	// Request capture. A single-bit request is a range of one bit.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q  <= req.mode;
			start_q <= req.start_bit;
			if (req.mode == MODE_SET_BIT || req.mode == MODE_CLEAR_BIT) begin
				len_q <= LEN_W'(1);
			end else begin
				len_q <= req.run_length;
			end
		end
	end

	// Map size in use and the end of the requested range.
	assign words_used = (wiu_q > CFG_W'(MAP_WORDS)) ? CFG_W'(MAP_WORDS) : wiu_q;
	assign total      = LEN_W'({words_used, {WORD_SH{1'b0}}});
	assign end_bit    = (LEN_W+1)'(start_q) + (LEN_W+1)'(len_q);
	assign last_bit   = BIT_W'(end_bit - (LEN_W+1)'(1));
	assign is_set     = (mode_q == MODE_SET_BIT) || (mode_q == MODE_SET_RANGE);

	// Decode: requests that finish without touching the map, and the rest.
	// Clear-all is kept apart so that only it wipes the map.
	always_comb begin
		kind      = KIND_EARLY;
		is_search = 1'b0;
		early_st  = ST_DONE;
		unique case (mode_q)
			MODE_SEARCH: begin
				is_search = 1'b1;
				if (len_q == '0 || len_q > total) begin
					early_st = ST_NOT_FOUND;
				end else begin
					kind = KIND_SEARCH;
				end
			end
			MODE_SET_BIT, MODE_CLEAR_BIT, MODE_SET_RANGE, MODE_CLEAR_RANGE: begin
				if (end_bit > (LEN_W+1)'(total)) begin
					early_st = ST_REJECTED;
				end else if (len_q != '0) begin
					kind = KIND_RMW;
				end
			end
			MODE_CLEAR_ALL: begin
				kind     = KIND_CLEAR;
				early_st = ST_DONE;
			end
			default: begin
				early_st = ST_REJECTED;
			end
		endcase
	end

	// Word pointer for the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			last_q   <= '0;
		end else if (cmd.load_ptr) begin
			if (is_search) begin
				rd_ptr_q <= '0;
				last_q   <= ADDR_W'(words_used - CFG_W'(1));
			end else begin
				rd_ptr_q <= start_q[BIT_W-1 -: ADDR_W];
				last_q   <= last_bit[BIT_W-1 -: ADDR_W];
			end
		end else if (cmd.rd_en) begin
			rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
		end
	end

	// Read stage: the word comes back from the RAM in the cycle after its address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		word_idx_s1 <= rd_ptr_q;
		vld_s1      <= valid_q[rd_ptr_q];
	end

	assign wr_fire = cmd.wr_en && rd_valid_s1;

	bra_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (wr_fire),
		.waddr (word_idx_s1),
		.wdata (new_word),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// A word never written since reset, or a word in use not written since clear-all, reads as zero.
	assign word_cur = vld_s1 ? ram_rdata : '0;

	// Per-word valid bits; clear-all drops those of the words in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.clear_map) begin
				for (int w = 0; w < MAP_WORDS; w++) begin
					if (CFG_W'(w) < words_used) begin
						valid_q[w] <= 1'b0;
					end
				end
			end
			if (wr_fire) begin
				valid_q[word_idx_s1] <= 1'b1;
			end
		end
	end

	// Range update of one word. Bit i of the word in map order sits at 31-i.
	always_comb begin
		logic [WORD_BITS-1:0] mw;
		logic [BIT_W-1:0]     g;
		mw = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			g = {word_idx_s1, WORD_SH'(i)};
			mw[WORD_BITS-1-i] = (g >= start_q) && ((LEN_W+1)'(g) < end_bit);
		end
		new_word = is_set ? (word_cur | mw) : (word_cur & ~mw);
	end

	// Run search over one word. Position j completes a run when the window of
	// len_q bits ending at j is clear and the clear bits carried in from the
	// previous words make up for any part of the window before this word.
	always_comb begin
		logic [WORD_BITS-1:0] v;
		logic [WORD_BITS-1:0] gt;
		logic [WORD_BITS-1:0] m;
		logic                 ge;
		v  = '0;
		gt = '0;
		m  = '0;
		ge = 1'b0;
		for (int i = 0; i < WORD_BITS; i++) begin
			v[i]  = word_cur[WORD_BITS-1-i];
			gt[i] = len_q > LEN_W'(i);
		end
		for (int j = 0; j < WORD_BITS; j++) begin
			m = '0;
			for (int i = 0; i < WORD_BITS; i++) begin
				if (i <= j) begin
					m[i] = gt[j-i];
				end
			end
			ge = ((LEN_W+1)'(carry_q) + (LEN_W+1)'(j + 1)) >= (LEN_W+1)'(len_q);
			hit_vec[j] = ~|(v & m) && ge;
		end
	end

	assign hit_any = |hit_vec;

	// First position that completes a run.
	always_comb begin
		hit_pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_pos = WORD_SH'(j);
			end
		end
	end

	assign found_calc = LEN_W'({word_idx_s1, hit_pos}) + LEN_W'(1) - len_q;

	// Clear bits at the tail of this word, carried into the next one.
	always_comb begin
		logic [WORD_SH-1:0] last_set;
		last_set = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (word_cur[WORD_BITS-1-i]) begin
				last_set = WORD_SH'(i);
			end
		end
		if (word_cur == '0) begin
			carry_nxt = carry_q + LEN_W'(WORD_BITS);
		end else begin
			carry_nxt = LEN_W'(WORD_BITS - 1) - LEN_W'(last_set);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else if (cmd.load_ptr) begin
			carry_q <= '0;
		end else if (rd_valid_s1) begin
			carry_q <= carry_nxt;
		end
	end

	// Result capture, then the output word register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			unique case (cmd.cap_sel)
				CAP_EARLY: res_q <= '{status: early_st, found_bit: '0};
				CAP_HIT:   res_q <= '{status: ST_DONE, found_bit: found_calc[BIT_W-1:0]};
				CAP_MISS:  res_q <= '{status: ST_NOT_FOUND, found_bit: '0};
				CAP_DONE:  res_q <= '{status: ST_DONE, found_bit: '0};
			endcase
		end
		if (cmd.rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

	// Status toward the controller.
	assign sts.kind       = kind;
	assign sts.is_search  = is_search;
	assign sts.rd_at_last = (rd_ptr_q == last_q);
	assign sts.hit        = rd_valid_s1 && is_search && hit_any;

endmodule

>>> sv/bra_ctrl.sv
`timescale 1ns / 1ps

module bra_ctrl import bra_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  bra_sts_t sts,
	output bra_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Sequencing of one request.
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.load_ptr = 1'b1;
				if (sts.kind == KIND_EARLY || sts.kind == KIND_CLEAR) begin
					cmd.capture   = 1'b1;
					cmd.cap_sel   = CAP_EARLY;
					cmd.clear_map = (sts.kind == KIND_CLEAR);
					state_nxt     = S_FINISH;
				end else begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				cmd.wr_en = ~sts.is_search;
				if (sts.hit) begin
					cmd.capture = 1'b1;
					cmd.cap_sel = CAP_HIT;
					state_nxt   = S_FINISH;
				end else if (sts.rd_at_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.wr_en   = ~sts.is_search;
				cmd.capture = 1'b1;
				if (!sts.is_search) begin
					cmd.cap_sel = CAP_DONE;
				end else if (sts.hit) begin
					cmd.cap_sel = CAP_HIT;
				end else begin
					cmd.cap_sel = CAP_MISS;
				end
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.rsp_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/bitmap_run_allocator_unit.sv
// Requests that do not read the map, clear-all among them, go from decode to the response;
// a search or range over N words scans them with one RAM read per word.
// One request in flight: the next is taken only after the last one's response is loaded.
// A search stops at the word where the run completes, so N is at most words_in_use.
// Reset: map words read as zero through per-word valid bits, words_in_use is 32.
`timescale 1ns / 1ps

module bitmap_run_allocator_unit import bra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  bra_req_t         req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output bra_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	bra_cmd_t cmd;
	bra_sts_t sts;

	bra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bra_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

>>> sv/bra_checker.sv
`timescale 1ns / 1ps

module bra_checker import bra_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input bra_req_t req,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input bra_rsp_t rsp
);

	// A response word waiting for the sink holds still.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// Only the three defined status codes appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_DONE || rsp.status == ST_NOT_FOUND ||
			rsp.status == ST_REJECTED))
		else $error("undefined status code");

	// A found index is reported only with a successful result.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_DONE |-> rsp.found_bit == '0)
		else $error("found index set on a failed request");

	// One request at a time: no accept in the cycle after an accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

endmodule

bind bitmap_run_allocator_unit bra_checker u_bra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
